FILE: rtl/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, command codes and sizes for the Piet stack machine executor.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int WORD_BITS         = 32;
  localparam int STACK_DEPTH_DEF   = 256;
  localparam int HUE_COUNT         = 6;
  localparam int LIGHT_COUNT       = 3;

  typedef logic [4:0]           op_t;
  typedef logic [WORD_BITS-1:0] word_t;

  localparam op_t OP_NOP  = 5'd0;
  localparam op_t OP_PUSH = 5'd1;
  localparam op_t OP_POP  = 5'd2;
  localparam op_t OP_ADD  = 5'd3;
  localparam op_t OP_SUB  = 5'd4;
  localparam op_t OP_MUL  = 5'd5;
  localparam op_t OP_DIV  = 5'd6;
  localparam op_t OP_MOD  = 5'd7;
  localparam op_t OP_NOT  = 5'd8;
  localparam op_t OP_GT   = 5'd9;
  localparam op_t OP_PTR  = 5'd10;
  localparam op_t OP_SWC  = 5'd11;
  localparam op_t OP_DUP  = 5'd12;
  localparam op_t OP_ROLL = 5'd13;
  localparam op_t OP_INN  = 5'd14;
  localparam op_t OP_INC  = 5'd15;
  localparam op_t OP_OUTN = 5'd16;
  localparam op_t OP_OUTC = 5'd17;

  typedef struct packed {
    logic  start;
    op_t   op;
    word_t a;
    word_t b;
  } alu_ctl_t;

  typedef struct packed {
    logic  done;
    word_t res;
    word_t quot;
    word_t rem;
  } alu_sts_t;

endpackage

FILE: rtl/psm_decode.sv
// ----------------------------------------------------------------------------
// psm_decode
// Command decode from hue and lightness change between two colour codes.
// ----------------------------------------------------------------------------
module psm_decode (
  input  logic [4:0]    current_color,
  input  logic [4:0]    next_color,
  output psm_pkg::op_t  op
);
  import psm_pkg::*;

  logic [1:0] cl, nl;
  logic [4:0] cl6, nl6;
  logic [2:0] ch, nh;
  logic [3:0] hd;
  logic [2:0] ld;
  logic [2:0] hc;
  logic [1:0] lc;

  always_comb begin
    cl = (current_color >= 5'd12) ? 2'd2 : (current_color >= 5'd6) ? 2'd1 : 2'd0;
    nl = (next_color >= 5'd12) ? 2'd2 : (next_color >= 5'd6) ? 2'd1 : 2'd0;
    cl6 = {1'b0, cl, 2'b00} + {2'b00, cl, 1'b0};
    nl6 = {1'b0, nl, 2'b00} + {2'b00, nl, 1'b0};
    ch = 3'(current_color - cl6);
    nh = 3'(next_color - nl6);
    hd = {1'b0, nh} + 4'(HUE_COUNT) - {1'b0, ch};
    hc = (hd >= 4'(HUE_COUNT)) ? 3'(hd - 4'(HUE_COUNT)) : hd[2:0];
    ld = {1'b0, nl} + 3'(LIGHT_COUNT) - {1'b0, cl};
    lc = (ld >= 3'(LIGHT_COUNT)) ? 2'(ld - 3'(LIGHT_COUNT)) : ld[1:0];
    if (current_color < 5'd18 && next_color < 5'd18) begin
      op = {1'b0, hc, 1'b0} + {2'b00, hc} + {3'b000, lc};
    end else begin
      op = OP_NOP;
    end
  end

endmodule

FILE: rtl/psm_alu.sv
// ----------------------------------------------------------------------------
// psm_alu
// Shared arithmetic unit: combinational add, sub, mul, compare, not, and a
// bit-serial restoring divider giving truncated quotient and floored remainder.
// ----------------------------------------------------------------------------
module psm_alu (
  input  logic              clk,
  input  logic              rst,
  input  psm_pkg::alu_ctl_t ctl,
  input  psm_pkg::word_t    s,
  input  psm_pkg::word_t    t,
  output psm_pkg::alu_sts_t sts
);
  import psm_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int IW = $clog2(W + 1);

  logic          busy;
  logic          done;
  logic [IW-1:0] iter;
  word_t         quo;
  word_t         rem;
  word_t         ub;
  logic          a_neg;
  logic          b_neg;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  word_t         rem_out;

  always_comb begin
    rem_sh = {rem, quo[W-1]};
    diff   = rem_sh - {1'b0, ub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        iter  <= IW'(W);
        quo   <= ctl.a[W-1] ? (~ctl.a + 1'b1) : ctl.a;
        ub    <= ctl.b[W-1] ? (~ctl.b + 1'b1) : ctl.b;
        rem   <= '0;
        a_neg <= ctl.a[W-1];
        b_neg <= ctl.b[W-1];
      end else if (busy) begin
        rem  <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
        quo  <= {quo[W-2:0], ~diff[W]};
        iter <= iter - 1'b1;
        if (iter == IW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (rem == '0) begin
      rem_out = '0;
    end else if (a_neg == b_neg) begin
      rem_out = b_neg ? (~rem + 1'b1) : rem;
    end else begin
      rem_out = b_neg ? (rem - ub) : (ub - rem);
    end
  end

  always_comb begin
    sts.done = done;
    sts.quot = (a_neg ^ b_neg) ? (~quo + 1'b1) : quo;
    sts.rem  = rem_out;
    case (ctl.op)
      OP_ADD:  sts.res = s + t;
      OP_SUB:  sts.res = s - t;
      OP_MUL:  sts.res = W'(s * t);
      OP_GT:   sts.res = ($signed(s) > $signed(t)) ? W'(1) : '0;
      OP_NOT:  sts.res = (t == '0) ? W'(1) : '0;
      default: sts.res = '0;
    endcase
  end

  a_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> ctl.b != '0) else $error("divider started with zero divisor");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while still iterating");

endmodule

FILE: rtl/piet_stack_machine_execute.sv
// ----------------------------------------------------------------------------
// piet_stack_machine_execute
// Executes one Piet command per input beat on a bounded word stack.
// Each beat reads the top and second stack entries, then executes; div and mod
// then run the shared divider, and roll with a nonzero depth runs it for the
// count modulo and then copies d entries out to the buffer and back.
// Only one command is in flight; the next
// beat is taken the cycle after the result is loaded, which waits for a free
// result register. Reset clears state, stack count, pointer, chooser and result valid.
// ----------------------------------------------------------------------------
module piet_stack_machine_execute #(
  parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [4:0]            current_color,
  input  logic [4:0]            next_color,
  input  logic [15:0]           block_size,
  input  logic signed [31:0]    in_value,
  output logic                  result_valid,
  input  logic                  result_ready,
  output psm_pkg::op_t          op_code,
  output logic                  out_valid,
  output logic signed [31:0]    out_value,
  output logic                  out_is_char,
  output logic [1:0]            pointer_dir,
  output logic                  chooser,
  output logic [8:0]            depth,
  output logic                  ignored
);
  import psm_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDT   = 3'd1;
  localparam logic [2:0] S_RDS   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_ROUT  = 3'd5;
  localparam logic [2:0] S_RBACK = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  word_t mem  [STACK_DEPTH];
  word_t rbuf [STACK_DEPTH];

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [1:0]    dp;
  logic          cc;
  op_t           op;
  op_t           dec_op;
  logic [15:0]   bsz;
  word_t         inv;
  word_t         t;
  logic          ign_r;
  logic          ov_r;
  word_t         oval_r;
  logic          och_r;
  logic [CW-1:0] base;
  logic [CW-1:0] dlen;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic          pv;

  word_t         rdata;
  word_t         brdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] braddr;
  logic          we;
  logic [AW-1:0] waddr;
  word_t         wdata;
  logic          bwe;
  logic [AW-1:0] bwaddr;
  word_t         bwdata;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] base_i;
  logic [CW-1:0] base_j;
  logic          full;
  logic          has1;
  logic          has2;
  logic          roll_ok;
  logic          div_go;

  alu_ctl_t      actl;
  alu_sts_t      asts;

  psm_decode u_decode (
    .current_color (current_color),
    .next_color    (next_color),
    .op            (dec_op)
  );

  psm_alu u_alu (
    .clk (clk),
    .rst (rst),
    .ctl (actl),
    .s   (rdata),
    .t   (t),
    .sts (asts)
  );

  always_comb begin
    cnt_m1  = cnt - 1'b1;
    cnt_m2  = cnt - 2'd2;
    base_i  = base + i;
    base_j  = base + j;
    full    = cnt >= CW'(STACK_DEPTH);
    has1    = cnt >= CW'(1);
    has2    = cnt >= CW'(2);
    roll_ok = !rdata[W-1] && (rdata <= W'(cnt_m2));
    div_go  = ((op == OP_DIV || op == OP_MOD) && has2 && t != '0) ||
              (op == OP_ROLL && has2 && roll_ok && rdata != '0);
    actl.start = (state == S_EXEC) && div_go;
    actl.op    = op;
    actl.a     = (op == OP_ROLL) ? t : rdata;
    actl.b     = (op == OP_ROLL) ? rdata : t;
  end

  always_comb begin
    raddr  = '0;
    braddr = '0;
    we     = 1'b0;
    waddr  = '0;
    wdata  = '0;
    bwe    = 1'b0;
    bwaddr = '0;
    bwdata = '0;
    case (state)
      S_RDT: raddr = cnt_m1[AW-1:0];
      S_RDS: raddr = cnt_m2[AW-1:0];
      S_EXEC: begin
        case (op)
          OP_PUSH, OP_INN, OP_INC: begin
            we    = !full;
            waddr = cnt[AW-1:0];
            wdata = (op == OP_PUSH) ? W'(bsz) : inv;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_GT: begin
            we    = has2;
            waddr = cnt_m2[AW-1:0];
            wdata = asts.res;
          end
          OP_NOT: begin
            we    = has1;
            waddr = cnt_m1[AW-1:0];
            wdata = asts.res;
          end
          OP_DUP: begin
            we    = has1 && !full;
            waddr = cnt[AW-1:0];
            wdata = t;
          end
          default: we = 1'b0;
        endcase
      end
      S_DIV: begin
        we    = asts.done && op != OP_ROLL;
        waddr = cnt_m2[AW-1:0];
        wdata = (op == OP_DIV) ? asts.quot : asts.rem;
      end
      S_ROUT: begin
        raddr  = base_i[AW-1:0];
        bwe    = pv;
        bwaddr = j[AW-1:0];
        bwdata = rdata;
      end
      S_RBACK: begin
        braddr = i[AW-1:0];
        we     = pv;
        waddr  = base_j[AW-1:0];
        wdata  = brdata;
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata  <= mem[raddr];
    brdata <= rbuf[braddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (bwe) begin
      rbuf[bwaddr] <= bwdata;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      dp           <= 2'd0;
      cc           <= 1'b0;
      result_valid <= 1'b0;
      pv           <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op     <= dec_op;
            bsz    <= block_size;
            inv    <= W'(in_value);
            ign_r  <= 1'b0;
            ov_r   <= 1'b0;
            oval_r <= '0;
            och_r  <= 1'b0;
            state  <= S_RDT;
          end
        end
        S_RDT: state <= S_RDS;
        S_RDS: begin
          t     <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= div_go ? S_DIV : S_DONE;
          case (op)
            OP_PUSH, OP_INN, OP_INC, OP_DUP: begin
              if (full || (op == OP_DUP && !has1)) begin
                ign_r <= 1'b1;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
            OP_POP: begin
              if (has1) cnt <= cnt_m1;
              else ign_r <= 1'b1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_GT: begin
              if (has2) cnt <= cnt_m1;
              else ign_r <= 1'b1;
            end
            OP_DIV, OP_MOD: begin
              if (!has2 || t == '0) ign_r <= 1'b1;
            end
            OP_NOT: begin
              if (!has1) ign_r <= 1'b1;
            end
            OP_PTR, OP_SWC, OP_OUTN, OP_OUTC: begin
              if (!has1) begin
                ign_r <= 1'b1;
              end else begin
                cnt <= cnt_m1;
                if (op == OP_PTR) begin
                  dp <= dp + t[1:0];
                end else if (op == OP_SWC) begin
                  cc <= cc ^ t[0];
                end else begin
                  ov_r   <= 1'b1;
                  oval_r <= t;
                  och_r  <= (op == OP_OUTC);
                end
              end
            end
            OP_ROLL: begin
              if (!has2 || !roll_ok) begin
                ign_r <= 1'b1;
              end else begin
                cnt  <= cnt_m2;
                dlen <= rdata[CW-1:0];
                base <= cnt_m2 - rdata[CW-1:0];
              end
            end
            default: ign_r <= 1'b0;
          endcase
        end
        S_DIV: begin
          if (asts.done) begin
            if (op == OP_ROLL) begin
              i     <= '0;
              j     <= asts.rem[CW-1:0];
              pv    <= 1'b0;
              state <= S_ROUT;
            end else begin
              cnt   <= cnt_m1;
              state <= S_DONE;
            end
          end
        end
        S_ROUT: begin
          pv <= (i != dlen);
          if (i != dlen) i <= i + 1'b1;
          if (pv) j <= (j + 1'b1 == dlen) ? '0 : j + 1'b1;
          if (i == dlen && !pv) begin
            i     <= '0;
            j     <= '0;
            state <= S_RBACK;
          end
        end
        S_RBACK: begin
          pv <= (i != dlen);
          if (i != dlen) i <= i + 1'b1;
          if (pv) j <= j + 1'b1;
          if (i == dlen && !pv) state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            op_code      <= op;
            out_valid    <= ov_r;
            out_value    <= oval_r;
            out_is_char  <= och_r;
            pointer_dir  <= dp;
            chooser      <= cc;
            depth        <= 9'(cnt);
            ignored      <= ign_r;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_out_cmd: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_valid) |-> (op_code == OP_OUTN || op_code == OP_OUTC))
    else $error("output value from a non-output command");
  a_roll_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUT || state == S_RBACK) |-> (i <= dlen && j < CW'(STACK_DEPTH)))
    else $error("roll copy index out of range");

endmodule
